### sv/rgb565_dither_pixel_packer_defines.svh
// Assertion macros shared by the pixel packer modules.
`ifndef RGB565_DITHER_PIXEL_PACKER_DEFINES_SVH
`define RGB565_DITHER_PIXEL_PACKER_DEFINES_SVH

// Condition that must hold at every edge out of reset.
`define RDPP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rdpp: invariant violated");

// Same-cycle implication.
`define RDPP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdpp: implication violated");

// Next-cycle implication.
`define RDPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdpp: next-cycle check violated");

`endif

### sv/rdpp_pkg.sv
// Types, constants and the dither table of the pixel packer.
package rdpp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned OUT_ADDR_W = 18;

  // luma weights and gray rounding
  localparam logic [15:0] LUMA_WR    = 16'd77;
  localparam logic [15:0] LUMA_WG    = 16'd150;
  localparam logic [15:0] LUMA_WB    = 16'd29;
  localparam logic [18:0] GRAY_ROUND = 19'(255 * 128);
  localparam logic [18:0] GRAY_DIV   = 19'(255 * 256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MONO_MODE  = 3'd0,
    REG_ROTATION   = 3'd1,
    REG_WIN_LEFT   = 3'd2,
    REG_WIN_TOP    = 3'd3,
    REG_WIN_WIDTH  = 3'd4,
    REG_WIN_HEIGHT = 3'd5
  } cfg_reg_t;

  // per-pixel request from the coordinate stage to the RMW stage
  typedef struct packed {
    logic        we;
    logic        mono;
    logic [2:0]  sub;
    logic [3:0]  dith;
    logic [15:0] luma;
    logic        done;
  } req_t;

  typedef struct packed {
    logic clearing;
    logic can_take;
  } rmw_status_t;

  localparam logic [3:0] DITHER [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  function automatic logic [3:0] dither_at(input logic [1:0] y, input logic [1:0] x);
    return DITHER[y][x];
  endfunction

endpackage

### sv/rdpp_if.sv
// Stream and configuration channel interfaces of the pixel packer.
interface rdpp_pix_if;
  logic                            valid;
  logic                            ready;
  logic [rdpp_pkg::COLOR_W-1:0]    color;
  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

interface rdpp_res_if;
  logic                             valid;
  logic                             ready;
  logic                             write_valid;
  logic [rdpp_pkg::OUT_ADDR_W-1:0]  byte_address;
  logic [7:0]                       byte_value;
  logic                             window_done;
  modport source (output valid, output write_valid, output byte_address,
                  output byte_value, output window_done, input ready);
  modport sink   (input valid, input write_valid, input byte_address,
                  input byte_value, input window_done, output ready);
endinterface

interface rdpp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rdpp_pkg::CFG_IDX_W-1:0]    index;
  logic [rdpp_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/rdpp_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module rdpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/rdpp_ctrl.sv
// Config registers, window counters, rotation and framebuffer address generation.
`include "rgb565_dither_pixel_packer_defines.svh"

module rdpp_ctrl #(
  parameter int unsigned PANEL_WIDTH  = 800,
  parameter int unsigned PANEL_HEIGHT = 600,
  parameter int unsigned ADDR_W       = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rdpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              accept,
  input  logic [rdpp_pkg::COLOR_W-1:0]      color,
  output rdpp_pkg::req_t                    req,
  output logic [ADDR_W-1:0]                 addr
);

  localparam logic signed [12:0] PW = 13'(PANEL_WIDTH);
  localparam logic signed [12:0] PH = 13'(PANEL_HEIGHT);
  localparam logic [ADDR_W-1:0] MONO_ROW = ADDR_W'(PANEL_WIDTH / 8);
  localparam logic [ADDR_W-1:0] GRAY_ROW = ADDR_W'(PANEL_WIDTH / 2);

  logic        mono_r, mono_nxt;
  logic [1:0]  rot_r, rot_nxt;
  logic [10:0] left_r, left_nxt;
  logic [10:0] win_top_r, win_top_nxt;
  logic [10:0] width_r, width_nxt;
  logic [10:0] height_r, height_nxt;
  logic [10:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;

  logic              active;
  logic signed [12:0] lx, ly, lw, lh, px_s, py_s;
  logic              inb;
  logic [11:0]       px, py;
  logic [10:0]       col_inc, row_inc;
  logic              done;
  logic [7:0]        r8, g8, b8;

  assign active = (width_r != 11'd0) && (height_r != 11'd0);

  // logical position, bounds and quarter-turn rotation
  always_comb begin
    lx = $signed({{2{left_r[10]}}, left_r}) + $signed({2'b00, col_r});
    ly = $signed({{2{win_top_r[10]}}, win_top_r}) + $signed({2'b00, row_r});
    lw = rot_r[0] ? PH : PW;
    lh = rot_r[0] ? PW : PH;
    inb = (lx >= 13'sd0) && (ly >= 13'sd0) && (lx < lw) && (ly < lh);
    unique case (rot_r)
      2'd1: begin
        px_s = PW - 13'sd1 - ly;
        py_s = lx;
      end
      2'd2: begin
        px_s = PW - 13'sd1 - lx;
        py_s = PH - 13'sd1 - ly;
      end
      2'd3: begin
        px_s = ly;
        py_s = PH - 13'sd1 - lx;
      end
      default: begin
        px_s = lx;
        py_s = ly;
      end
    endcase
    px = px_s[11:0];
    py = py_s[11:0];
  end

  always_comb begin
    if (mono_r) begin
      addr = MONO_ROW * ADDR_W'(py) + ADDR_W'(px >> 3);
    end else begin
      addr = GRAY_ROW * ADDR_W'(py) + ADDR_W'(px >> 1);
    end
  end

  // RGB565 widened to 8 bits per channel, then weighted luma
  always_comb begin
    r8 = {color[15:11], color[15:13]};
    g8 = {color[10:5], color[10:9]};
    b8 = {color[4:0], color[4:2]};
  end

  // counters advance after each transfer within a non-empty window
  always_comb begin
    col_inc = col_r + 11'd1;
    row_inc = row_r + 11'd1;
    done    = 1'b0;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && active) begin
      if ((col_inc >= width_r) || (col_inc == 11'd0)) begin
        col_nxt = 11'd0;
        if ((row_inc >= height_r) || (row_inc == 11'd0)) begin
          row_nxt = 11'd0;
          done    = 1'b1;
        end else begin
          row_nxt = row_inc;
        end
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_comb begin
    req.we   = active && inb;
    req.mono = mono_r;
    req.sub  = mono_r ? px[2:0] : {2'b00, px[0]};
    req.dith = rdpp_pkg::dither_at(ly[1:0], lx[1:0]);
    req.luma = 16'(r8) * rdpp_pkg::LUMA_WR + 16'(g8) * rdpp_pkg::LUMA_WG
             + 16'(b8) * rdpp_pkg::LUMA_WB;
    req.done = done;
  end

  // config writes take precedence; window writes restart the window
  always_comb begin
    mono_nxt    = mono_r;
    rot_nxt     = rot_r;
    left_nxt    = left_r;
    win_top_nxt = win_top_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rdpp_pkg::REG_MONO_MODE:  mono_nxt    = cfg_data[0];
        rdpp_pkg::REG_ROTATION:   rot_nxt     = cfg_data[1:0];
        rdpp_pkg::REG_WIN_LEFT:   left_nxt    = cfg_data;
        rdpp_pkg::REG_WIN_TOP:    win_top_nxt = cfg_data;
        rdpp_pkg::REG_WIN_WIDTH:  width_nxt   = cfg_data;
        rdpp_pkg::REG_WIN_HEIGHT: height_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r    <= 1'b0;
      rot_r     <= 2'd0;
      left_r    <= 11'd0;
      win_top_r <= 11'd0;
      width_r   <= 11'd0;
      height_r  <= 11'd0;
      col_r     <= 11'd0;
      row_r     <= 11'd0;
    end else begin
      mono_r    <= mono_nxt;
      rot_r     <= rot_nxt;
      left_r    <= left_nxt;
      win_top_r <= win_top_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      if (cfg_we && ((cfg_index == rdpp_pkg::REG_WIN_LEFT) ||
                     (cfg_index == rdpp_pkg::REG_WIN_TOP) ||
                     (cfg_index == rdpp_pkg::REG_WIN_WIDTH) ||
                     (cfg_index == rdpp_pkg::REG_WIN_HEIGHT))) begin
        col_r <= 11'd0;
        row_r <= 11'd0;
      end else begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  `RDPP_ASSERT_IMPLY(a_empty_win_idle, !active, (col_r == 11'd0) && (row_r == 11'd0))
  `RDPP_ASSERT_IMPLY(a_col_in_win, width_r != 11'd0, col_r < width_r)
  `RDPP_ASSERT_IMPLY(a_row_in_win, height_r != 11'd0, row_r < height_r)

endmodule

### sv/rdpp_rmw.sv
// Framebuffer read-modify-write stage, clearing sweep and output register.
`include "rgb565_dither_pixel_packer_defines.svh"

module rdpp_rmw #(
  parameter int unsigned DEPTH  = 240000,
  parameter int unsigned ADDR_W = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  rdpp_pkg::req_t                    req,
  input  logic [ADDR_W-1:0]                 addr,
  input  logic                              out_ready,
  output rdpp_pkg::rmw_status_t             status,
  output logic                              out_valid,
  output logic                              out_write_valid,
  output logic [rdpp_pkg::OUT_ADDR_W-1:0]   out_byte_address,
  output logic [7:0]                        out_byte_value,
  output logic                              out_window_done
);

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic              s1_valid_r;
  rdpp_pkg::req_t    s1_req_r;
  logic [ADDR_W-1:0] s1_addr_r;

  logic              last_we_r;
  logic [ADDR_W-1:0] last_addr_r;
  logic [7:0]        last_data_r;

  logic              out_valid_r;
  logic              out_wv_r;
  logic [rdpp_pkg::OUT_ADDR_W-1:0] out_addr_r;
  logic [7:0]        out_val_r;
  logic              out_done_r;

  logic              s1_adv;
  logic [7:0]        rd_data, old_byte, new_byte, bitmask;
  logic [7:0]        thr;
  logic [18:0]       gray_v;
  logic [2:0]        level;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [31:0]       addr_ext;

  assign s1_adv          = s1_valid_r && (!out_valid_r || out_ready);
  assign status.clearing = clearing_r;
  assign status.can_take = !s1_valid_r || s1_adv;

  // merge; previous write forwarded over a same-cycle read
  always_comb begin
    old_byte = (last_we_r && (last_addr_r == s1_addr_r)) ? last_data_r : rd_data;
    bitmask  = 8'd1 << s1_req_r.sub;
    thr      = {s1_req_r.dith, 4'b1000};
    gray_v   = 19'(s1_req_r.luma) * 19'd7 + rdpp_pkg::GRAY_ROUND;
    level    = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (gray_v >= 19'(k) * rdpp_pkg::GRAY_DIV) begin
        level = 3'(k);
      end
    end
    if (s1_req_r.mono) begin
      new_byte = old_byte & ~bitmask;
      if (s1_req_r.luma[15:8] < thr) begin
        new_byte = new_byte | bitmask;
      end
    end else if (s1_req_r.sub[0]) begin
      new_byte = (old_byte & 8'hF0) | {5'b00000, level};
    end else begin
      new_byte = (old_byte & 8'h0F) | {1'b0, level, 4'b0000};
    end
  end

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = s1_adv && s1_req_r.we;
      ram_waddr = s1_addr_r;
      ram_wdata = new_byte;
    end
  end

  rdpp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_fb (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign addr_ext = 32'(s1_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      last_we_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_req_r.we) begin
        last_we_r <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r  <= req;
      s1_addr_r <= addr;
    end
    if (s1_adv && s1_req_r.we) begin
      last_addr_r <= s1_addr_r;
      last_data_r <= new_byte;
    end
    if (s1_adv) begin
      out_wv_r   <= s1_req_r.we;
      out_addr_r <= s1_req_r.we ? addr_ext[rdpp_pkg::OUT_ADDR_W-1:0] : '0;
      out_val_r  <= s1_req_r.we ? new_byte : 8'h00;
      out_done_r <= s1_req_r.done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_valid  = out_wv_r;
  assign out_byte_address = out_addr_r;
  assign out_byte_value   = out_val_r;
  assign out_window_done  = out_done_r;

  `RDPP_ASSERT_IMPLY(a_no_pixel_in_clear, clearing_r, !s1_valid_r)
  `RDPP_ASSERT_NEXT(a_last_write_tracked, s1_adv && s1_req_r.we,
                    last_we_r && (last_addr_r == $past(s1_addr_r)))

endmodule

### sv/rgb565_dither_pixel_packer.sv
// Top level of the RGB565 ordered-dither pixel packer.
// RGB565 pixels arrive in raster order over a window set through the config
// channel; each transfer yields exactly one result transfer describing the
// framebuffer byte it rewrote (or write_valid low if the pixel fell outside the
// rotated panel or the window is empty). Mono mode packs one bit per pixel from
// a 4x4 Bayer threshold; gray mode packs a rounded 3-bit level per nibble. The
// block sustains one pixel per clock while results are taken: stage 0 forms the
// rotated address and luma and issues the framebuffer read, stage 1 merges and
// writes back, with the previous write forwarded so back-to-back pixels into one
// byte are correct, then a result register feeds the output. The result passes
// through the stage 1 register and then the result register, where a stalled
// result channel can hold it. A full result register does not stop input while
// stage 1 is free. After reset the single framebuffer write port clears all
// PANEL_WIDTH*PANEL_HEIGHT/2 bytes of the store (240000 at the defaults), during
// which no pixel is taken; config writes are taken at all times. Config may only
// be written while no pixel is in flight; writes to the window registers
// restart the window counters.
module rgb565_dither_pixel_packer #(
  parameter int unsigned PANEL_WIDTH  = 800,
  parameter int unsigned PANEL_HEIGHT = 600
) (
  input  logic        clk,
  input  logic        rst_n,
  rdpp_pix_if.sink    in_pix,
  rdpp_res_if.source  out_res,
  rdpp_cfg_if.sink    cfg_wr
);

  localparam int unsigned STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 2;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

  rdpp_pkg::req_t        req;
  rdpp_pkg::rmw_status_t rmw_st;
  logic [ADDR_W-1:0]     req_addr;
  logic                  in_accept;
  logic                  cfg_we;

  // pixel transfer only once the clear is done and stage 1 can take it
  assign in_pix.ready = !rmw_st.clearing && rmw_st.can_take;
  assign in_accept    = in_pix.valid && in_pix.ready;

  assign cfg_wr.ready = 1'b1;
  assign cfg_we       = cfg_wr.valid && cfg_wr.ready;

  rdpp_ctrl #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .accept    (in_accept),
    .color     (in_pix.color),
    .req       (req),
    .addr      (req_addr)
  );

  rdpp_rmw #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_rmw (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_accept),
    .req              (req),
    .addr             (req_addr),
    .out_ready        (out_res.ready),
    .status           (rmw_st),
    .out_valid        (out_res.valid),
    .out_write_valid  (out_res.write_valid),
    .out_byte_address (out_res.byte_address),
    .out_byte_value   (out_res.byte_value),
    .out_window_done  (out_res.window_done)
  );

endmodule

### tb/tb_rgb565_dither_pixel_packer.sv
// Self-checking testbench for the RGB565 ordered-dither pixel packer.
`timescale 1ns / 100ps

module tb_rgb565_dither_pixel_packer;

  // Panel geometry; the framebuffer holds two pixels per byte in gray mode.
  localparam int PANEL_W     = 800;
  localparam int PANEL_H     = 600;
  localparam int STORE_BYTES = PANEL_W * PANEL_H / 2;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [rdpp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rdpp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int TOTAL_ITEMS  = 1150;
  localparam int SETTLE_TICKS = 4;     // pipeline is two stages deep
  localparam int HOLD_AT      = 800;   // sink stalls for a long stretch here
  localparam int HOLD_TICKS   = 120;
  // The post-reset clear of the store writes all STORE_BYTES bytes with no pixel
  // taken, so the stall limit has to sit well above the length of that clear.
  localparam int STALL_LIMIT  = 4 * STORE_BYTES + 20000;

  // 4x4 ordered-dither thresholds, indexed [y & 3][x & 3].
  localparam int unsigned THRESHOLD_MAP [4][4] = '{
    '{0, 8, 2, 10},
    '{12, 4, 14, 6},
    '{3, 11, 1, 9},
    '{15, 7, 13, 5}
  };

  // One framebuffer update as reported on the result channel.
  typedef struct {
    bit        write_valid;
    bit [17:0] byte_address;
    bit [7:0]  byte_value;
    bit        window_done;
  } fb_write_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: mirrors the window counters and the whole framebuffer, works
  // out the byte each accepted pixel rewrites and checks results in order.
  // ---------------------------------------------------------------------------
  class pixel_scoreboard;
    bit        mono;
    bit [1:0]  rot;
    int        win_left, win_top;
    bit [10:0] win_w, win_h;
    bit [10:0] col, row;
    bit [7:0]  frame [STORE_BYTES];
    fb_write_t expected_writes [$];
    int        errors;

    function void write_reg(logic [rdpp_pkg::CFG_IDX_W-1:0] idx,
                            logic [rdpp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rdpp_pkg::REG_MONO_MODE:  mono = data[0];
        rdpp_pkg::REG_ROTATION:   rot  = data[1:0];
        rdpp_pkg::REG_WIN_LEFT:   begin win_left = $signed(data); col = 0; row = 0; end
        rdpp_pkg::REG_WIN_TOP:    begin win_top  = $signed(data); col = 0; row = 0; end
        rdpp_pkg::REG_WIN_WIDTH:  begin win_w = data; col = 0; row = 0; end
        rdpp_pkg::REG_WIN_HEIGHT: begin win_h = data; col = 0; row = 0; end
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [15:0] colour);
      fb_write_t   upd;
      int          lx, ly, lw, lh;
      int unsigned r8, g8, b8, luma, px, py, addr, level, thr;
      bit [7:0]    mask, cur;
      upd = '{default: 0};
      if (win_w != 0 && win_h != 0) begin
        lx = win_left + int'(col);
        ly = win_top + int'(row);
        lw = rot[0] ? PANEL_H : PANEL_W;
        lh = rot[0] ? PANEL_W : PANEL_H;
        // widen 5/6-bit channels by replicating their top bits
        r8 = {colour[15:11], colour[15:13]};
        g8 = {colour[10:5], colour[10:9]};
        b8 = {colour[4:0], colour[4:2]};
        luma = r8 * 77 + g8 * 150 + b8 * 29;
        if (lx >= 0 && ly >= 0 && lx < lw && ly < lh) begin
          case (rot)
            2'd1:    begin px = PANEL_W - 1 - ly; py = lx; end
            2'd2:    begin px = PANEL_W - 1 - lx; py = PANEL_H - 1 - ly; end
            2'd3:    begin px = ly; py = PANEL_H - 1 - lx; end
            default: begin px = lx; py = ly; end
          endcase
          if (mono) begin
            // threshold uses logical coordinates, bit position physical ones
            thr  = THRESHOLD_MAP[ly[1:0]][lx[1:0]] * 16 + 8;
            mask = 8'(1 << px[2:0]);
            addr = (PANEL_W / 8) * py + px / 8;
            if (addr < STORE_BYTES) begin
              cur = frame[addr] & ~mask;
              if ((luma >> 8) < thr) cur |= mask;
              frame[addr] = cur;
              upd = '{1'b1, 18'(addr), cur, 1'b0};
            end
          end else begin
            level = (luma * 7 + 255 * 128) / (255 * 256);
            addr  = (PANEL_W / 2) * py + px / 2;
            if (addr < STORE_BYTES) begin
              // odd pixel in the low nibble, even in the high one
              cur = px[0] ? {frame[addr][7:4], 4'(level)} : {4'(level), frame[addr][3:0]};
              frame[addr] = cur;
              upd = '{1'b1, 18'(addr), cur, 1'b0};
            end
          end
        end
        // raster advance; an 11-bit wrap to zero also ends the row/window
        col = col + 1'b1;
        if (col >= win_w || col == 0) begin
          col = 0;
          row = row + 1'b1;
          if (row >= win_h || row == 0) begin
            row = 0;
            upd.window_done = 1'b1;
          end
        end
      end
      expected_writes.push_back(upd);
    endfunction

    function void check_result(logic wv, logic [17:0] addr, logic [7:0] val, logic done);
      fb_write_t exp_w;
      if (expected_writes.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        errors++;
        return;
      end
      exp_w = expected_writes.pop_front();
      if (wv !== exp_w.write_valid) begin
        $error("write_valid: expected %0d, got %0d", exp_w.write_valid, wv);
        errors++;
      end
      if (addr !== exp_w.byte_address) begin
        $error("byte_address: expected %0d, got %0d", exp_w.byte_address, addr);
        errors++;
      end
      if (val !== exp_w.byte_value) begin
        $error("byte_value: expected 0x%02h, got 0x%02h", exp_w.byte_value, val);
        errors++;
      end
      if (done !== exp_w.window_done) begin
        $error("window_done: expected %0d, got %0d", exp_w.window_done, done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rdpp_pix_if pix ();
  rdpp_res_if res ();
  rdpp_cfg_if cfg ();

  pixel_scoreboard board;
  int sent_count = 0;
  int stall_ticks = 0;
  bit long_hold_done = 1'b0;

  rgb565_dither_pixel_packer #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix),
    .out_res(res),
    .cfg_wr (cfg)
  );

  always #5 clk = ~clk;

  // Idle rates by stretch of the run: sender-light first, then sink-light,
  // then back-to-back on both sides.
  function automatic int sender_idle_pct();
    if (sent_count < TOTAL_ITEMS / 3) return 18;
    if (sent_count < 2 * TOTAL_ITEMS / 3) return 57;
    return 0;
  endfunction

  function automatic int sink_idle_pct();
    if (sent_count < TOTAL_ITEMS / 3) return 57;
    if (sent_count < 2 * TOTAL_ITEMS / 3) return 18;
    return 0;
  endfunction

  // Offer one pixel and hold it until the transfer. valid is left high on
  // return so that a following pixel never lowers and raises it in one step.
  task automatic send_pixel(input logic [15:0] colour);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.color <= colour;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    board.note_pixel(colour);
    sent_count++;
  endtask

  // Config write; valid is lowered by the caller once the batch is done.
  task automatic write_reg(input logic [rdpp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rdpp_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Stop offering pixels and wait until every expected result has come out,
  // plus the pipeline depth, before config may be touched.
  task automatic settle_pipeline();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic setup_window(input bit mono, input bit [1:0] rot,
                              input int left, input int top, input int w, input int h);
    settle_pipeline();
    write_reg(rdpp_pkg::REG_MONO_MODE, rdpp_pkg::CFG_DATA_W'(mono));
    write_reg(rdpp_pkg::REG_ROTATION, rdpp_pkg::CFG_DATA_W'(rot));
    write_reg(rdpp_pkg::REG_WIN_LEFT, rdpp_pkg::CFG_DATA_W'(left));
    write_reg(rdpp_pkg::REG_WIN_TOP, rdpp_pkg::CFG_DATA_W'(top));
    write_reg(rdpp_pkg::REG_WIN_WIDTH, rdpp_pkg::CFG_DATA_W'(w));
    write_reg(rdpp_pkg::REG_WIN_HEIGHT, rdpp_pkg::CFG_DATA_W'(h));
    cfg.valid <= 1'b0;
  endtask

  // Window origin along one axis: straddling the near edge, straddling the
  // far edge, or somewhere fully inside the panel.
  function automatic int window_origin(input int lim, input int span);
    case ($urandom_range(0, 2))
      0:       return int'($urandom_range(0, 6)) - 3;
      1:       return lim - span + int'($urandom_range(0, 6)) - 3;
      default: return int'($urandom_range(0, lim - span));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, plus one long hold-off while the
  // sender keeps pushing so the pipeline fills and stalls the input.
  // ---------------------------------------------------------------------------
  initial begin
    res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!long_hold_done && sent_count >= HOLD_AT && pix.valid) begin
        res.ready <= 1'b0;
        repeat (HOLD_TICKS) @(posedge clk);
        long_hold_done = 1'b1;
      end
      res.ready <= ($urandom_range(0, 99) >= sink_idle_pct());
    end
  end

  // Result monitor: every result transfer is checked against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready)
      board.check_result(res.write_valid, res.byte_address, res.byte_value, res.window_done);
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_ticks = 0;
    end else begin
      stall_ticks++;
      if (stall_ticks >= STALL_LIMIT) begin
        $display("rgb565_dither_pixel_packer test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    bit [1:0]    rot;
    int          w, h, n;
    logic [15:0] colour;

    pix.valid <= 1'b0;
    pix.color <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data  <= '0;
    rst_n     <= 1'b0;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty window straight out of reset: pixels are swallowed, no write,
    // no window_done. The first pixel also waits out the store clear.
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    // width alone set, height still zero: still empty
    settle_pipeline();
    write_reg(rdpp_pkg::REG_WIN_WIDTH, 11'd3);
    cfg.valid <= 1'b0;
    send_pixel(16'h8410);

    // Mono, window hanging off the left edge; colour extremes and primaries.
    setup_window(1'b1, 2'd0, -1, 0, 3, 2);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    send_pixel(16'h8410);

    // Gray, quarter turn, window in the swapped far corner, hanging off the far x edge.
    setup_window(1'b0, 2'd1, 598, 798, 3, 2);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'h7BEF);
    send_pixel(16'hFFFF);
    send_pixel(16'h0841);
    send_pixel(16'hF7DE);

    // Register extremes: most negative origin with a 1024 by 1024 window,
    // then most positive origin with all-ones sizes. All off-panel.
    setup_window(1'b1, 2'd2, -1024, -1024, 1024, 1024);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    setup_window(1'b0, 2'd3, 1023, 1023, 2047, 2047);
    send_pixel(16'h5555);
    send_pixel(16'hAAAA);

    // Mode change mid-window: counters carry on, the shared byte keeps its
    // gray nibble while mono bits land in it. Writes past the register list
    // are ignored and do not restart the window.
    setup_window(1'b0, 2'd0, 0, 0, 4, 2);
    send_pixel(16'hFFFF);
    send_pixel(16'h39E7);
    settle_pipeline();
    write_reg(rdpp_pkg::REG_MONO_MODE, 11'd1);
    write_reg(REG_SPARE_LO, 11'h7FF);
    write_reg(REG_SPARE_HI, 11'h000);
    cfg.valid <= 1'b0;
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8410);

    // Random phases. Most are small windows near the panel edges so that
    // drops, rotation, window_done and nibble/bit sharing all get hit; some
    // keep the running window and only flip mode or rotation; a few use
    // raw random register values (mostly off-panel or empty windows).
    while (sent_count < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          settle_pipeline();
          write_reg(rdpp_pkg::REG_MONO_MODE, rdpp_pkg::CFG_DATA_W'($urandom_range(0, 1)));
          if ($urandom_range(0, 1))
            write_reg(rdpp_pkg::REG_ROTATION, rdpp_pkg::CFG_DATA_W'($urandom_range(0, 3)));
          cfg.valid <= 1'b0;
        end
        9: begin
          w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 2047));
          h = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 2047));
          setup_window(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       int'($urandom_range(0, 2047)), int'($urandom_range(0, 2047)), w, h);
        end
        default: begin
          rot = 2'($urandom_range(0, 3));
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 6);
          setup_window(1'($urandom_range(0, 1)), rot,
                       window_origin(rot[0] ? PANEL_H : PANEL_W, w),
                       window_origin(rot[0] ? PANEL_W : PANEL_H, h), w, h);
        end
      endcase
      n = $urandom_range(4, 48);
      repeat (n) begin
        colour = ($urandom_range(0, 7) == 0) ?
                 ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : 16'($urandom_range(0, 65535));
        send_pixel(colour);
      end
    end

    // Drain, then give any stray result time to show up.
    settle_pipeline();
    repeat (4 * SETTLE_TICKS) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("rgb565_dither_pixel_packer test passed");
    end else begin
      $display("rgb565_dither_pixel_packer test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/rdpp_pkg.sv
sv/rdpp_if.sv
sv/rdpp_ram.sv
sv/rdpp_ctrl.sv
sv/rdpp_rmw.sv
sv/rgb565_dither_pixel_packer.sv
tb/tb_rgb565_dither_pixel_packer.sv
